### rtl/core/akt_pkg.sv
// akt_pkg: shared types and constants for the active key table
// no dependencies; imported by akt_ram users and active_key_table_core
package akt_pkg;

  // default table capacity
  localparam int MaxKeysDef = 8;

  // command codes of an input word
  typedef enum logic [1:0] {
    CMD_PRESS   = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_QUERY   = 2'd2,
    CMD_FLUSH   = 2'd3
  } cmd_e;

  // one table entry as held in the entry ram
  typedef struct packed {
    logic [15:0] code;
    logic [31:0] down_time;
    logic [31:0] repeat_delay;
  } entry_t;

endpackage

### rtl/core/akt_ram.sv
// akt_ram: generic single write, single read port ram with registered read
// no dependencies
module akt_ram #(
  parameter int Width = 8,
  parameter int Depth = 8
) (
  input  logic                                clk_i,
  input  logic                                we_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                    wdata_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                    rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/active_key_table_core.sv
// active_key_table_core: table of held keys with sequential search
// depends on akt_pkg and akt_ram
//
// usage:
//   input channel (in_valid_i / in_stall_o) carries one command word: press,
//   release, query or flush, with a key code and two opaque 32-bit words
//   that a press stores. output channel (out_valid_o / out_stall_i) returns
//   exactly one result word per command: found, slot, key count, dropped.
//   a word moves at a rising edge with valid high and stall low.
//   one command is worked at a time; in_stall_o is high while it runs.
//   the entry ram has one read port, so the search compares one slot per
//   cycle from slot 0 upward, and a release that moves the last entry
//   passes through a move read and a move write state.
//   flush, a press on a full table and any command on an empty table skip
//   the search. the done state loads the result once the output is free.
//   the result sits in an output register, so a new command is taken while
//   a result still waits; a stalled receiver only holds the next result.
//   reset clears the entry count, the sequencer and the output valid; the
//   entry ram is not cleared, only slots below the count are ever read.
module active_key_table_core
  import akt_pkg::*;
#(
  parameter int MAX_KEYS = MaxKeysDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // command channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  command_i,
  input  logic [15:0] key_id_i,
  input  logic [31:0] down_time_i,
  input  logic [31:0] repeat_delay_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        found_o,
  output logic [2:0]  slot_index_o,
  output logic [3:0]  key_count_o,
  output logic        dropped_o
);

  localparam int IDX_W = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int CNT_W = $clog2(MAX_KEYS + 1);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_KEYS);
  localparam logic [CNT_W-1:0] ONE_CNT = CNT_W'(1);

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_MV_RD = 3'd2;
  localparam logic [2:0] S_MV_WR = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]       state_q, state_d;
  cmd_e             cmd_q, cmd_d;
  logic [15:0]      code_q, code_d;
  logic [31:0]      time_q, time_d;
  logic [31:0]      delay_q, delay_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic             pend_q, pend_d;
  logic             res_found_q, res_found_d;
  logic [IDX_W-1:0] res_slot_q, res_slot_d;
  logic             res_drop_q, res_drop_d;

  // output register
  logic             out_valid_q, out_valid_d;
  logic             out_found_q, out_found_d;
  logic [2:0]       out_slot_q, out_slot_d;
  logic [3:0]       out_count_q, out_count_d;
  logic             out_drop_q, out_drop_d;

  // entry ram port
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  entry_t           ram_wdata;
  logic [IDX_W-1:0] ram_raddr;
  logic [$bits(entry_t)-1:0] ram_rdata;
  entry_t           rd_entry;

  logic             in_acc;
  logic             hit;
  logic [IDX_W-1:0] hit_slot;
  logic [IDX_W-1:0] last_idx;
  entry_t           in_entry;
  entry_t           held_entry;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign rd_entry   = ram_rdata;
  assign in_entry   = '{code: key_id_i, down_time: down_time_i,
                        repeat_delay: repeat_delay_i};
  assign held_entry = '{code: code_q, down_time: time_q, repeat_delay: delay_q};

  // compare stage sees the slot read issued in the previous cycle
  assign hit      = pend_q && (rd_entry.code == code_q);
  assign hit_slot = IDX_W'(idx_q - ONE_CNT);
  assign last_idx = IDX_W'(count_q - ONE_CNT);

  akt_ram #(
    .Width ($bits(entry_t)),
    .Depth (MAX_KEYS)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    code_d      = code_q;
    time_d      = time_q;
    delay_d     = delay_q;
    count_d     = count_q;
    idx_d       = idx_q;
    pend_d      = pend_q;
    res_found_d = res_found_q;
    res_slot_d  = res_slot_q;
    res_drop_d  = res_drop_q;
    ram_we      = 1'b0;
    ram_waddr   = idx_q[IDX_W-1:0];
    ram_wdata   = held_entry;
    ram_raddr   = idx_q[IDX_W-1:0];

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          cmd_d       = cmd_e'(command_i);
          code_d      = key_id_i;
          time_d      = down_time_i;
          delay_d     = repeat_delay_i;
          res_found_d = 1'b0;
          res_slot_d  = '0;
          res_drop_d  = 1'b0;
          idx_d       = '0;
          pend_d      = 1'b0;
          case (cmd_e'(command_i))
            CMD_FLUSH: begin
              count_d = '0;
              state_d = S_DONE;
            end
            CMD_PRESS: begin
              if (count_q == MAX_CNT) begin
                // full table drops the press without a search
                res_drop_d = 1'b1;
                state_d    = S_DONE;
              end else if (count_q == '0) begin
                // empty table: append into slot 0 at once
                ram_we    = 1'b1;
                ram_waddr = '0;
                ram_wdata = in_entry;
                count_d   = ONE_CNT;
                state_d   = S_DONE;
              end else begin
                state_d = S_SCAN;
              end
            end
            default: begin
              if (count_q == '0) begin
                state_d = S_DONE;
              end else begin
                state_d = S_SCAN;
              end
            end
          endcase
        end
      end

      S_SCAN: begin
        if (hit) begin
          res_found_d = 1'b1;
          res_slot_d  = hit_slot;
          case (cmd_q)
            CMD_PRESS: begin
              // refresh time and delay words in place
              ram_we    = 1'b1;
              ram_waddr = hit_slot;
              state_d   = S_DONE;
            end
            CMD_RELEASE: begin
              if (hit_slot == last_idx) begin
                count_d = count_q - ONE_CNT;
                state_d = S_DONE;
              end else begin
                state_d = S_MV_RD;
              end
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end else if (pend_q && (idx_q == count_q)) begin
          // every live slot compared, no match
          if (cmd_q == CMD_PRESS) begin
            ram_we     = 1'b1;
            ram_waddr  = count_q[IDX_W-1:0];
            res_slot_d = count_q[IDX_W-1:0];
            count_d    = count_q + ONE_CNT;
          end
          state_d = S_DONE;
        end else begin
          ram_raddr = idx_q[IDX_W-1:0];
          idx_d     = idx_q + ONE_CNT;
          pend_d    = 1'b1;
        end
      end

      S_MV_RD: begin
        ram_raddr = last_idx;
        state_d   = S_MV_WR;
      end

      S_MV_WR: begin
        // last entry fills the released slot
        ram_we    = 1'b1;
        ram_waddr = res_slot_q;
        ram_wdata = rd_entry;
        count_d   = count_q - ONE_CNT;
        state_d   = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // output register loads when the sequencer leaves the done state
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    out_found_d = out_found_q;
    out_slot_d  = out_slot_q;
    out_count_d = out_count_q;
    out_drop_d  = out_drop_q;
    if ((state_q == S_DONE) && (!out_valid_q || !out_stall_i)) begin
      out_valid_d = 1'b1;
      out_found_d = res_found_q;
      out_slot_d  = 3'(res_slot_q);
      out_count_d = 4'(count_q);
      out_drop_d  = res_drop_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload and result staging, no reset needed
  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    code_q      <= code_d;
    time_q      <= time_d;
    delay_q     <= delay_d;
    res_found_q <= res_found_d;
    res_slot_q  <= res_slot_d;
    res_drop_q  <= res_drop_d;
    out_found_q <= out_found_d;
    out_slot_q  <= out_slot_d;
    out_count_q <= out_count_d;
    out_drop_q  <= out_drop_d;
  end

  assign out_valid_o  = out_valid_q;
  assign found_o      = out_found_q;
  assign slot_index_o = out_slot_q;
  assign key_count_o  = out_count_q;
  assign dropped_o    = out_drop_q;

  // count stays within capacity
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= MAX_CNT)
    else $error("entry count above capacity");

  // a flush empties the table
  a_flush_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (command_i == CMD_FLUSH)) |=> (count_q == '0))
    else $error("flush did not clear the count");

  // a press on a full table leaves the count alone
  a_full_press_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (command_i == CMD_PRESS) && (count_q == MAX_CNT)) |=> $stable(count_q))
    else $error("dropped press changed the count");

  // the ram is only written while a command is worked
  a_write_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && (state_q != S_IDLE)) |-> (ram_waddr < count_d || state_q == S_MV_WR
      || cmd_q == CMD_PRESS))
    else $error("entry write outside the live slots");

  // a dropped press reports no match and slot zero
  a_drop_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && dropped_o) |-> (!found_o && (slot_index_o == 3'd0)))
    else $error("dropped result carries a match");

endmodule
